// ===== hw/rtl/ssds_pkg.sv =====
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared types and constants for the Stokeslet direct-sum engine.
// ----------------------------------------------------------------------------
package ssds_pkg;

	// opcodes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EVAL_SRC = 2'd1;
	localparam logic [1:0] OP_EVAL_EXT = 2'd2;

	// register indexes
	localparam logic [1:0] REG_N_SOURCES = 2'd0;
	localparam logic [1:0] REG_TARGET_COUNT = 2'd1;

	localparam int VEL_W = 48;
	localparam int RUN_MAX = 1024;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TGT_RD,
		ST_TGT,
		ST_SRC_RD,
		ST_DIFF,
		ST_NORM,
		ST_SHIFT,
		ST_SQ,
		ST_SEED,
		ST_N1,
		ST_N2,
		ST_N3,
		ST_RH,
		ST_DOT,
		ST_D,
		ST_H,
		ST_G,
		ST_P,
		ST_ACC,
		ST_FIN
	} state_t;

	// inverse square root seed, Q30, indexed by the top bits of the square sum
	function automatic logic [32:0] isqrt_seed(input logic [3:0] sel);
		logic [32:0] v;
		case (sel)
			4'd0: v = 33'd2147483648;
			4'd1: v = 33'd1753412885;
			4'd2: v = 33'd1358187860;
			4'd3: v = 33'd1147878329;
			4'd4: v = 33'd1012333544;
			4'd5: v = 33'd915689494;
			4'd6: v = 33'd842311878;
			4'd7: v = 33'd784150414;
			4'd8: v = 33'd736580466;
			4'd9: v = 33'd696736011;
			4'd10: v = 33'd662727175;
			default: v = 33'd633258725;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/stokeslet_direct_sum.sv =====
// ----------------------------------------------------------------------------
// stokeslet_direct_sum
// Fixed-point free-space Stokeslet direct sum over a source memory.
// ----------------------------------------------------------------------------
// Loads (opcode 0) write one source into the source memory in the cycle the
// item is accepted. An evaluation walks sources 0 .. n_sources-1 (capped at
// MAX_SOURCES) through one source memory and one shared pair sequencer; each
// source is read, differenced, normalized, squared, given an inverse square
// root by Newton steps and accumulated, skipped sources are only read and
// differenced, and an evaluation at a stored point first reads its target.
// The result sits in an output register, so the next item may be accepted
// while it waits. There is no clearing pass.
module stokeslet_direct_sum #(
	parameter int MAX_SOURCES = 1024,
	parameter int COORD_WIDTH = 32,
	parameter int ISQRT_ITERATIONS = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [10:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] opcode,
	input  logic [9:0] index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [47:0] vel_x,
	output logic signed [47:0] vel_y,
	output logic signed [47:0] vel_z,
	output logic coincident,
	output logic saturated,
	output logic last
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int RW = CW + 1;
	localparam int NW = (RW > 32) ? RW : 32;
	localparam int KW = $clog2(ISQRT_ITERATIONS + 1);
	localparam int RHW = 35;
	localparam int PW = RHW + CW;
	localparam int SW = PW + 2;
	localparam int DW = SW - 30;
	localparam int HW = RHW + DW;
	localparam int GW = HW - 29;
	localparam int PPW = GW + 24;
	localparam int SUMW = ((PPW > ssds_pkg::VEL_W) ? PPW : ssds_pkg::VEL_W) + 1;
	localparam logic [16:0] MAX_EXT = 17'(MAX_SOURCES);
	localparam logic [31:0] THREE_Q30 = 32'd3221225472;

	// configuration and run counter
	logic [10:0] nsrc_q, tcnt_q;
	logic [9:0] done_q;
	logic [16:0] ns_eff;
	logic [10:0] tc_eff;
	logic last_c;

	ssds_pkg::state_t state_q, state_d;

	// item registers
	logic self_q;
	logic [16:0] idx_q;
	logic signed [CW-1:0] tp_q [3];
	logic [16:0] n_q;

	// source memory: {fz, fy, fx, pz, py, px}
	logic [6*CW-1:0] mem [MAX_SOURCES];
	logic [6*CW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic load_en;
	logic [16:0] in_idx_ext;

	// pair datapath
	logic signed [CW-1:0] src_pos [3];
	logic signed [CW-1:0] src_f [3];
	logic signed [RW-1:0] diff_c [3];
	logic [RW-1:0] abs_c [3];
	logic [RW-1:0] max_c;
	logic signed [RW-1:0] r_q [3];
	logic signed [CW-1:0] f_q [3];
	logic [NW-1:0] m_q;
	logic [63:0] m64;
	logic [5:0] lsh_q, rsh_q;
	logic signed [31:0] rn_q [3];
	logic [63:0] sq_q [3];
	logic [63:0] q_c;
	logic [31:0] qs_q;
	logic [32:0] y_q;
	logic [35:0] y2_q;
	logic [37:0] t_c;
	logic [31:0] t_q;
	logic [KW-1:0] k_q;
	logic signed [RHW-1:0] rh_q [3];
	logic signed [PW-1:0] pr_q [3];
	logic signed [DW-1:0] d_q;
	logic signed [HW-1:0] h_q [3];
	logic signed [GW-1:0] g_q [3];
	logic signed [PPW-1:0] p_q [3];
	logic [6:0] sh_c;
	logic signed [ssds_pkg::VEL_W-1:0] acc_q [3];
	logic coin_q, sat_q;
	logic skip_c, zero_c, advance_c, end_c, norm_ok_c, out_load_c;
	logic signed [SUMW-1:0] sum_c [3];
	logic signed [ssds_pkg::VEL_W-1:0] accn_c [3];
	logic [2:0] satc_c;
	logic in_acc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ssds_pkg::ST_IDLE);
	assign in_idx_ext = 17'(index);
	assign load_en = in_acc && (opcode == ssds_pkg::OP_LOAD) && (in_idx_ext < MAX_EXT);

	assign ns_eff = (17'(nsrc_q) > MAX_EXT) ? MAX_EXT : 17'(nsrc_q);
	assign tc_eff = (tcnt_q == 11'd0 || tcnt_q > 11'(ssds_pkg::RUN_MAX)) ?
		11'(ssds_pkg::RUN_MAX) : tcnt_q;
	assign last_c = (11'(done_q) + 11'd1) >= tc_eff;

	// configuration registers and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsrc_q <= 11'd1;
			tcnt_q <= 11'd1;
			done_q <= '0;
		end else begin
			if (cfg_we && cfg_index == ssds_pkg::REG_N_SOURCES) nsrc_q <= cfg_data;
			if (cfg_we && cfg_index == ssds_pkg::REG_TARGET_COUNT) begin
				tcnt_q <= cfg_data;
				done_q <= '0;
			end else if (out_load_c) begin
				done_q <= last_c ? 10'd0 : 10'(11'(done_q) + 11'd1);
			end
		end
	end

	// source memory, read data registered; loads are only accepted while the
	// sequencer is idle, so no load overlaps a read that the sequencer uses
	always_comb begin
		if (state_q == ssds_pkg::ST_TGT_RD) rd_addr = idx_q[AW-1:0];
		else rd_addr = n_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			mem[in_idx_ext[AW-1:0]] <= {CW'(force_z), CW'(force_y), CW'(force_x),
				CW'(pos_z), CW'(pos_y), CW'(pos_x)};
		end
		rd_q <= mem[rd_addr];
	end

	// split the read word, form offsets
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			src_pos[i] = $signed(rd_q[i*CW +: CW]);
			src_f[i] = $signed(rd_q[(i+3)*CW +: CW]);
			diff_c[i] = RW'(tp_q[i]) - RW'(src_pos[i]);
			abs_c[i] = diff_c[i][RW-1] ? RW'(-diff_c[i]) : RW'(diff_c[i]);
		end
		max_c = abs_c[0];
		if (abs_c[1] > max_c) max_c = abs_c[1];
		if (abs_c[2] > max_c) max_c = abs_c[2];
		zero_c = (diff_c[0] == '0) && (diff_c[1] == '0) && (diff_c[2] == '0);
		skip_c = self_q && (n_q == idx_q);
	end

	// normalization range check and shared arithmetic
	assign m64 = 64'(m_q);
	assign norm_ok_c = (m64 >= 64'h4000_0000) && (m64 < 64'h8000_0000);
	assign q_c = sq_q[0] + sq_q[1] + sq_q[2];
	assign t_c = 38'((68'(qs_q) * 68'(y2_q)) >> 30);
	assign sh_c = 7'd31 + 7'(rsh_q) - 7'(lsh_q);

	// saturating accumulate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SUMW'(acc_q[i]) + SUMW'(p_q[i] >>> sh_c);
			satc_c[i] = 1'b0;
			if (sum_c[i] > SUMW'(48'sh7FFF_FFFF_FFFF)) begin
				accn_c[i] = 48'sh7FFF_FFFF_FFFF;
				satc_c[i] = 1'b1;
			end else if (sum_c[i] < SUMW'(48'sh8000_0000_0000)) begin
				accn_c[i] = 48'sh8000_0000_0000;
				satc_c[i] = 1'b1;
			end else begin
				accn_c[i] = 48'(sum_c[i]);
			end
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		advance_c = 1'b0;
		out_load_c = 1'b0;
		end_c = (n_q + 17'd1) >= ns_eff;
		unique case (state_q)
			ssds_pkg::ST_IDLE: begin
				if (in_acc && opcode == ssds_pkg::OP_EVAL_SRC && in_idx_ext < MAX_EXT)
					state_d = ssds_pkg::ST_TGT_RD;
				else if (in_acc && opcode == ssds_pkg::OP_EVAL_EXT)
					state_d = (ns_eff == '0) ? ssds_pkg::ST_FIN : ssds_pkg::ST_SRC_RD;
			end
			ssds_pkg::ST_TGT_RD: state_d = ssds_pkg::ST_TGT;
			ssds_pkg::ST_TGT:
				state_d = (ns_eff == '0) ? ssds_pkg::ST_FIN : ssds_pkg::ST_SRC_RD;
			ssds_pkg::ST_SRC_RD: state_d = ssds_pkg::ST_DIFF;
			ssds_pkg::ST_DIFF: begin
				if (skip_c || zero_c) begin
					advance_c = 1'b1;
					state_d = end_c ? ssds_pkg::ST_FIN : ssds_pkg::ST_SRC_RD;
				end else begin
					state_d = ssds_pkg::ST_NORM;
				end
			end
			ssds_pkg::ST_NORM: if (norm_ok_c) state_d = ssds_pkg::ST_SHIFT;
			ssds_pkg::ST_SHIFT: state_d = ssds_pkg::ST_SQ;
			ssds_pkg::ST_SQ: state_d = ssds_pkg::ST_SEED;
			ssds_pkg::ST_SEED: state_d = ssds_pkg::ST_N1;
			ssds_pkg::ST_N1: state_d = ssds_pkg::ST_N2;
			ssds_pkg::ST_N2: state_d = ssds_pkg::ST_N3;
			ssds_pkg::ST_N3:
				state_d = (32'(k_q) + 32'd1 >= 32'(ISQRT_ITERATIONS)) ?
					ssds_pkg::ST_RH : ssds_pkg::ST_N1;
			ssds_pkg::ST_RH: state_d = ssds_pkg::ST_DOT;
			ssds_pkg::ST_DOT: state_d = ssds_pkg::ST_D;
			ssds_pkg::ST_D: state_d = ssds_pkg::ST_H;
			ssds_pkg::ST_H: state_d = ssds_pkg::ST_G;
			ssds_pkg::ST_G: state_d = ssds_pkg::ST_P;
			ssds_pkg::ST_P: state_d = ssds_pkg::ST_ACC;
			ssds_pkg::ST_ACC: begin
				advance_c = 1'b1;
				state_d = end_c ? ssds_pkg::ST_FIN : ssds_pkg::ST_SRC_RD;
			end
			ssds_pkg::ST_FIN: begin
				if (!out_valid || !out_stall) begin
					out_load_c = 1'b1;
					state_d = ssds_pkg::ST_IDLE;
				end
			end
			default: state_d = ssds_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssds_pkg::ST_IDLE;
			out_valid <= 1'b0;
			n_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load_c) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (state_q == ssds_pkg::ST_IDLE) n_q <= '0;
			else if (advance_c) n_q <= n_q + 17'd1;
			if (state_q == ssds_pkg::ST_SEED) k_q <= '0;
			else if (state_q == ssds_pkg::ST_N3) k_q <= k_q + KW'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ssds_pkg::ST_IDLE: begin
				self_q <= (opcode == ssds_pkg::OP_EVAL_SRC);
				idx_q <= in_idx_ext;
				tp_q[0] <= CW'(pos_x);
				tp_q[1] <= CW'(pos_y);
				tp_q[2] <= CW'(pos_z);
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
				coin_q <= 1'b0;
				sat_q <= 1'b0;
			end
			ssds_pkg::ST_TGT: begin
				for (int i = 0; i < 3; i++) tp_q[i] <= src_pos[i];
			end
			ssds_pkg::ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					r_q[i] <= diff_c[i];
					f_q[i] <= src_f[i];
				end
				m_q <= NW'(max_c);
				lsh_q <= '0;
				rsh_q <= '0;
				if (!skip_c && zero_c) coin_q <= 1'b1;
			end
			// coarse then fine shift toward [2^30, 2^31)
			ssds_pkg::ST_NORM: begin
				if (m64 < 64'h40_0000) begin
					m_q <= m_q << 8;
					lsh_q <= lsh_q + 6'd8;
				end else if (m64 < 64'h4000_0000) begin
					m_q <= m_q << 1;
					lsh_q <= lsh_q + 6'd1;
				end else if (m64 >= 64'h80_0000_0000) begin
					m_q <= m_q >> 8;
					rsh_q <= rsh_q + 6'd8;
				end else if (m64 >= 64'h8000_0000) begin
					m_q <= m_q >> 1;
					rsh_q <= rsh_q + 6'd1;
				end
			end
			ssds_pkg::ST_SHIFT: begin
				for (int i = 0; i < 3; i++)
					rn_q[i] <= 32'((lsh_q != '0) ? (64'(r_q[i]) <<< lsh_q) :
						(64'(r_q[i]) >>> rsh_q));
			end
			ssds_pkg::ST_SQ: begin
				for (int i = 0; i < 3; i++) sq_q[i] <= 64'(rn_q[i]) * 64'(rn_q[i]);
			end
			ssds_pkg::ST_SEED: begin
				qs_q <= q_c[63:32];
				y_q <= ssds_pkg::isqrt_seed(q_c[63:60]);
			end
			ssds_pkg::ST_N1: y2_q <= 36'((66'(y_q) * 66'(y_q)) >> 30);
			ssds_pkg::ST_N2: t_q <= (t_c > 38'(THREE_Q30)) ? THREE_Q30 : t_c[31:0];
			ssds_pkg::ST_N3: y_q <= 33'((65'(y_q) * 65'(THREE_Q30 - t_q)) >> 31);
			ssds_pkg::ST_RH: begin
				for (int i = 0; i < 3; i++)
					rh_q[i] <= RHW'((66'(rn_q[i]) * $signed(66'(y_q))) >>> 31);
			end
			ssds_pkg::ST_DOT: begin
				for (int i = 0; i < 3; i++) pr_q[i] <= PW'(rh_q[i]) * PW'(f_q[i]);
			end
			ssds_pkg::ST_D: d_q <= DW'((SW'(pr_q[0]) + SW'(pr_q[1]) + SW'(pr_q[2])) >>> 30);
			ssds_pkg::ST_H: begin
				for (int i = 0; i < 3; i++) h_q[i] <= HW'(rh_q[i]) * HW'(d_q);
			end
			ssds_pkg::ST_G: begin
				for (int i = 0; i < 3; i++) g_q[i] <= GW'(f_q[i]) + GW'(h_q[i] >>> 30);
			end
			ssds_pkg::ST_P: begin
				for (int i = 0; i < 3; i++)
					p_q[i] <= PPW'(g_q[i]) * $signed(PPW'(y_q[32:10]));
			end
			ssds_pkg::ST_ACC: begin
				for (int i = 0; i < 3; i++) acc_q[i] <= accn_c[i];
				if (satc_c != '0) sat_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load_c) begin
			vel_x <= acc_q[0];
			vel_y <= acc_q[1];
			vel_z <= acc_q[2];
			coincident <= coin_q;
			saturated <= sat_q;
			last <= last_c;
		end
	end

	// run counter never reaches the run length
	a_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		11'(done_q) < tc_eff) else $error("run counter out of range");

	// a pair is only formed for a source inside the summed range
	a_src_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssds_pkg::ST_DIFF) |-> (n_q < ns_eff))
		else $error("source index beyond source count");

	// newton step count stays bounded
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssds_pkg::ST_N1) |-> (32'(k_q) < 32'(ISQRT_ITERATIONS)))
		else $error("too many newton steps");

	// the result register is only loaded when free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && state_q == ssds_pkg::ST_FIN) |=>
		(state_q == ssds_pkg::ST_FIN))
		else $error("pending result overwritten");

endmodule
